>>> rtl/kwm_pkg.sv
// Shared types and constants of the k-way heap merge engine.
// No dependencies; used by the stream interface instances and the top level.
package kwm_pkg;

	// Reach of the four-bit source field.
	localparam int SRC_REACH = 16;

	localparam int CMD_W  = 2;
	localparam int SRC_W  = 4;
	localparam int KEY_W  = 64;
	localparam int TERM_W = 32;
	localparam int NUM_W  = 5;

	localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_NUM_SOURCES = 1'b0;
	localparam logic [NUM_W-1:0] NUM_SOURCES_RESET = 5'd16;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SRC_W-1:0]  source;
		logic [KEY_W-1:0]  sort_key;
		logic [TERM_W-1:0] term_tag;
	} in_item_t;

	typedef struct packed {
		logic              record_valid;
		logic [SRC_W-1:0]  out_source;
		logic [KEY_W-1:0]  out_key;
		logic [TERM_W-1:0] out_term;
		logic              same_term;
		logic [SRC_W-1:0]  refill_source;
		logic              merge_done;
	} out_item_t;

endpackage

>>> rtl/kwm_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Instantiated with kwm_pkg::in_item_t or kwm_pkg::out_item_t as payload.
interface kwm_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/kwm_ram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
// No dependencies.
module kwm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end
endmodule

>>> rtl/kway_heap_merge.sv
// K-way merge engine: a binary min-heap of source indexes lives in one RAM and the head record
// (key and term) of every source in another; both have a registered read. Start a merge with
// command 0, then feed the first record or end of sources 0, 1, 2, ... in order; the engine
// stays ready between loading transactions. After the last source the heap is built bottom-up
// with sift-downs, and the minimum is emitted. From then on only the source named in
// refill_source is taken; a refill sifts through L heap levels, at most ceil(log2(heap size)),
// and each level needs a read of the heap RAM, a read of the head RAM and a compare. Results
// wait in an output register, so the next transaction is taken while a result is still pending;
// the result of that transaction is held back, and the engine with it, until the register has
// been emptied.
module kway_heap_merge #(
	parameter int MAX_WAYS  = 16,
	parameter int KEY_BITS  = 64,
	parameter int TERM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	kwm_stream_if.sink   items,
	kwm_stream_if.source results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int DEPTH = (MAX_WAYS < kwm_pkg::SRC_REACH) ? MAX_WAYS : kwm_pkg::SRC_REACH;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = IW + 2;
	localparam int HW = KEY_BITS + TERM_BITS;
	localparam int NW = kwm_pkg::NUM_W;
	localparam int SW = kwm_pkg::SRC_W;
	localparam int KO = kwm_pkg::KEY_W;
	localparam int TO = kwm_pkg::TERM_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RDLAST = 4'd1;
	localparam logic [3:0] S_LDORD  = 4'd2;
	localparam logic [3:0] S_LDSRC  = 4'd3;
	localparam logic [3:0] S_LDKEY  = 4'd4;
	localparam logic [3:0] S_LVL    = 4'd5;
	localparam logic [3:0] S_CH     = 4'd6;
	localparam logic [3:0] S_CMP    = 4'd7;
	localparam logic [3:0] S_EMRD   = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0]           state_q;
	logic [NW-1:0]        num_q;
	logic [CW-1:0]        heap_q;
	logic [CW-1:0]        loaded_q;
	logic                 merging_q;
	logic [TERM_BITS-1:0] last_term_q;
	logic                 last_valid_q;
	logic [IW-1:0]        root_q;
	logic [IW-1:0]        pos_q;
	logic [IW-1:0]        i_q;
	logic                 build_q;
	logic [IW-1:0]        cur_src_q;
	logic [KEY_BITS-1:0]  cur_key_q;
	logic [IW-1:0]        cl_src_q;
	logic [IW-1:0]        cr_src_q;
	logic                 out_valid_q;
	kwm_pkg::out_item_t   out_q;

	kwm_pkg::in_item_t    in_item;
	logic                 in_fire;
	logic [KEY_BITS-1:0]  in_key;
	logic [TERM_BITS-1:0] in_term;
	logic                 cmd_rec;
	logic                 cmd_end;
	logic [NW-1:0]        ways_n;
	logic                 loading;
	logic                 load_ok;
	logic                 refill_ok;
	logic                 last_load;
	logic [CW-1:0]        cnt_after;
	logic [CW-1:0]        build_i;

	logic [LW-1:0]        l_idx;
	logic [LW-1:0]        r_idx;
	logic                 has_l;
	logic                 has_r;
	logic [KEY_BITS-1:0]  key_l;
	logic [KEY_BITS-1:0]  key_r;
	logic [KEY_BITS-1:0]  best_key;
	logic                 take_l;
	logic                 take_r;
	logic                 move;
	logic [IW-1:0]        mv_src;
	logic [IW-1:0]        mv_pos;
	logic                 sift_end;
	logic                 can_load;

	logic                 ord_we;
	logic [IW-1:0]        ord_waddr;
	logic [IW-1:0]        ord_wdata;
	logic [IW-1:0]        ord_ra;
	logic [IW-1:0]        ord_rb;
	logic [IW-1:0]        ord_rd_a;
	logic [IW-1:0]        ord_rd_b;
	logic                 head_we;
	logic [HW-1:0]        head_wdata;
	logic [IW-1:0]        head_ra;
	logic [IW-1:0]        head_rb;
	logic [HW-1:0]        head_rd_a;
	logic [HW-1:0]        head_rd_b;
	logic [TERM_BITS-1:0] em_term;
	kwm_pkg::out_item_t   em_item;

	logic                 cfg_we;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == kwm_pkg::REG_NUM_SOURCES);
	always_comb begin
		prdata = '0;
		if (paddr[2] == kwm_pkg::REG_NUM_SOURCES) begin
			prdata = 32'(num_q);
		end
	end

	// Input decode.
	assign in_item = items.payload;
	assign items.ready = (state_q == S_IDLE);
	assign in_fire = items.valid && items.ready;
	assign in_key = KEY_BITS'(in_item.sort_key);
	assign in_term = TERM_BITS'(in_item.term_tag);
	assign cmd_rec = (in_item.command == kwm_pkg::CMD_RECORD);
	assign cmd_end = (in_item.command == kwm_pkg::CMD_END);

	always_comb begin
		if (num_q == '0) begin
			ways_n = NW'(1);
		end else if (num_q > NW'(DEPTH)) begin
			ways_n = NW'(DEPTH);
		end else begin
			ways_n = num_q;
		end
	end

	assign loading   = NW'(loaded_q) < ways_n;
	assign load_ok   = merging_q && loading && (cmd_rec || cmd_end)
		&& ({1'b0, in_item.source} == NW'(loaded_q));
	assign refill_ok = merging_q && !loading && (cmd_rec || cmd_end) && (heap_q != '0)
		&& ({1'b0, in_item.source} == NW'(root_q));
	assign last_load = (NW'(loaded_q) + NW'(1)) == ways_n;
	assign cnt_after = cmd_rec ? heap_q + CW'(1) : heap_q;
	assign build_i   = cnt_after >> 1;

	// Sift-down datapath: the sifted record stays in cur_*; only the heap slot it
	// leaves behind is rewritten at each level, and its own slot once at the end.
	assign l_idx    = LW'({pos_q, 1'b1});
	assign r_idx    = l_idx + LW'(1);
	assign has_l    = l_idx < LW'(heap_q);
	assign has_r    = r_idx < LW'(heap_q);
	assign key_l    = head_rd_a[HW-1 -: KEY_BITS];
	assign key_r    = head_rd_b[HW-1 -: KEY_BITS];
	assign take_l   = key_l < cur_key_q;
	assign best_key = take_l ? key_l : cur_key_q;
	assign take_r   = has_r && (key_r < best_key);
	assign move     = take_l || take_r;
	assign mv_src   = take_r ? cr_src_q : cl_src_q;
	assign mv_pos   = take_r ? IW'(r_idx) : IW'(l_idx);
	assign sift_end = ((state_q == S_LVL) && !has_l) || ((state_q == S_CMP) && !move);

	assign em_term  = head_rd_a[TERM_BITS-1:0];
	assign can_load = !out_valid_q || results.ready;

	// Result transaction built from the root's head record.
	always_comb begin
		em_item = '0;
		if (heap_q == '0) begin
			em_item.merge_done = 1'b1;
		end else begin
			em_item.record_valid  = 1'b1;
			em_item.out_source    = SW'(root_q);
			em_item.refill_source = SW'(root_q);
			em_item.out_key       = KO'(head_rd_a[HW-1 -: KEY_BITS]);
			em_item.out_term      = TO'(em_term);
			em_item.same_term     = last_valid_q && (em_term == last_term_q);
		end
	end

	// RAM port control.
	always_comb begin
		ord_we    = 1'b0;
		ord_waddr = pos_q;
		ord_wdata = cur_src_q;
		ord_ra    = pos_q;
		ord_rb    = pos_q;
		head_ra   = root_q;
		head_rb   = ord_rd_b;
		case (state_q)
			S_IDLE: begin
				ord_ra = IW'(heap_q - CW'(1));
				if (in_fire && load_ok && cmd_rec) begin
					ord_we    = 1'b1;
					ord_waddr = IW'(heap_q);
					ord_wdata = IW'(in_item.source);
				end
			end
			S_RDLAST: begin
				ord_we    = 1'b1;
				ord_waddr = '0;
				ord_wdata = ord_rd_a;
				head_ra   = ord_rd_a;
			end
			S_LDSRC: begin
				head_ra = ord_rd_a;
			end
			S_LVL: begin
				ord_ra = IW'(l_idx);
				ord_rb = IW'(r_idx);
				if (!has_l) begin
					ord_we = 1'b1;
				end
			end
			S_CH: begin
				head_ra = ord_rd_a;
				head_rb = ord_rd_b;
			end
			S_CMP: begin
				ord_we    = 1'b1;
				ord_wdata = move ? mv_src : cur_src_q;
			end
			default: begin
			end
		endcase
	end

	assign head_we    = in_fire && cmd_rec && (load_ok || refill_ok);
	assign head_wdata = {in_key, in_term};

	kwm_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_order_ram (
		.clk     (clk),
		.we      (ord_we),
		.waddr   (ord_waddr),
		.wdata   (ord_wdata),
		.raddr_a (ord_ra),
		.rdata_a (ord_rd_a),
		.raddr_b (ord_rb),
		.rdata_b (ord_rd_b)
	);

	kwm_ram #(.WIDTH(HW), .DEPTH(DEPTH)) u_head_ram (
		.clk     (clk),
		.we      (head_we),
		.waddr   (IW'(in_item.source)),
		.wdata   (head_wdata),
		.raddr_a (head_ra),
		.rdata_a (head_rd_a),
		.raddr_b (head_rb),
		.rdata_b (head_rd_b)
	);

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			num_q        <= kwm_pkg::NUM_SOURCES_RESET;
			heap_q       <= '0;
			loaded_q     <= '0;
			merging_q    <= 1'b0;
			last_term_q  <= '0;
			last_valid_q <= 1'b0;
			root_q       <= '0;
			pos_q        <= '0;
			i_q          <= '0;
			build_q      <= 1'b0;
			cur_src_q    <= '0;
			cur_key_q    <= '0;
			cl_src_q     <= '0;
			cr_src_q     <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				num_q <= pwdata[NW-1:0];
			end
			// The root slot is mirrored so that refill_source needs no RAM read.
			if (ord_we && (ord_waddr == '0)) begin
				root_q <= ord_wdata;
			end
			if ((state_q == S_EMIT) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && results.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_item.command == kwm_pkg::CMD_START) begin
							heap_q       <= '0;
							loaded_q     <= '0;
							merging_q    <= 1'b1;
							last_valid_q <= 1'b0;
							last_term_q  <= '0;
						end else if (load_ok) begin
							heap_q   <= cnt_after;
							loaded_q <= loaded_q + CW'(1);
							if (last_load) begin
								build_q <= 1'b1;
								if (build_i == '0) begin
									state_q <= S_EMRD;
								end else begin
									i_q     <= IW'(build_i - CW'(1));
									pos_q   <= IW'(build_i - CW'(1));
									state_q <= S_LDORD;
								end
							end
						end else if (refill_ok) begin
							build_q <= 1'b0;
							pos_q   <= '0;
							if (cmd_rec) begin
								cur_src_q <= root_q;
								cur_key_q <= in_key;
								state_q   <= (heap_q > CW'(1)) ? S_LVL : S_EMRD;
							end else begin
								heap_q  <= heap_q - CW'(1);
								state_q <= (heap_q == CW'(1)) ? S_EMRD : S_RDLAST;
							end
						end
					end
				end
				S_RDLAST: begin
					// The last leaf has just been moved to the root.
					cur_src_q <= ord_rd_a;
					state_q   <= (heap_q > CW'(1)) ? S_LDKEY : S_EMRD;
				end
				S_LDORD: begin
					state_q <= S_LDSRC;
				end
				S_LDSRC: begin
					cur_src_q <= ord_rd_a;
					state_q   <= S_LDKEY;
				end
				S_LDKEY: begin
					cur_key_q <= head_rd_a[HW-1 -: KEY_BITS];
					state_q   <= S_LVL;
				end
				S_LVL: begin
					if (has_l) begin
						state_q <= S_CH;
					end
				end
				S_CH: begin
					cl_src_q <= ord_rd_a;
					cr_src_q <= ord_rd_b;
					state_q  <= S_CMP;
				end
				S_CMP: begin
					if (move) begin
						pos_q   <= mv_pos;
						state_q <= S_LVL;
					end
				end
				S_EMRD: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (can_load) begin
						out_q <= em_item;
						if (heap_q == '0) begin
							merging_q <= 1'b0;
						end else begin
							last_term_q  <= em_term;
							last_valid_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// End of one sift-down: continue the heap build or emit the minimum.
			if (sift_end) begin
				if (build_q && (i_q != '0)) begin
					i_q     <= i_q - IW'(1);
					pos_q   <= i_q - IW'(1);
					state_q <= S_LDORD;
				end else begin
					state_q <= S_EMRD;
				end
			end
		end
	end

	a_heap_within_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		heap_q <= loaded_q)
		else $error("heap holds more records than sources loaded");

	a_sift_pos_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LVL) |-> (CW'(pos_q) < heap_q))
		else $error("sift position lies outside the heap");

	a_result_taken_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.ready && (state_q != S_EMIT)) |=> !results.valid)
		else $error("result repeated after its transaction");

	a_emit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EMIT) && !results.valid) |=> (results.valid && (state_q == S_IDLE)))
		else $error("emit state did not load the output register");

endmodule

>>> verif/kwm_merge_checker.sv
// Checker for the k-way heap merge engine: watches the item, result and configuration ports.
// Keeps its own heap of head records and compares every result transaction in order.
// Depends on kwm_pkg for the command codes, field widths and payload types.
module kwm_merge_checker
	import kwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  in_item_t    item,
	input  logic        result_valid,
	input  logic        result_ready,
	input  out_item_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned pending_results,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HEAP_DEPTH = SRC_REACH;

	logic [SRC_W-1:0]  heap_src [HEAP_DEPTH];
	logic [KEY_W-1:0]  head_key [HEAP_DEPTH];
	logic [TERM_W-1:0] head_term [HEAP_DEPTH];
	int unsigned       heap_size;
	int unsigned       loaded;
	bit                merging;
	logic [TERM_W-1:0] prev_term;
	bit                prev_term_valid;
	logic [NUM_W-1:0]  num_sources;
	out_item_t         expected_merge_out [$];
	int unsigned       mismatches;

	function automatic int unsigned active_ways();
		if (num_sources == 0)
			return 1;
		if (num_sources > HEAP_DEPTH)
			return HEAP_DEPTH;
		return num_sources;
	endfunction

	function automatic logic [KEY_W-1:0] key_at(int unsigned pos);
		return head_key[heap_src[pos]];
	endfunction

	// Strict less-than, so a child only moves up when its key is really smaller.
	function automatic void sift_down_from(int unsigned pos);
		int unsigned left, right, least;
		logic [SRC_W-1:0] held;
		while (1) begin
			left = 2 * pos + 1;
			right = left + 1;
			least = pos;
			if (left < heap_size && key_at(left) < key_at(pos))
				least = left;
			if (right < heap_size && key_at(right) < key_at(least))
				least = right;
			if (least == pos)
				break;
			held = heap_src[pos];
			heap_src[pos] = heap_src[least];
			heap_src[least] = held;
			pos = least;
		end
	endfunction

	function automatic void emit_minimum();
		out_item_t rec;
		logic [SRC_W-1:0] src;
		rec = '0;
		if (heap_size == 0) begin
			merging = 1'b0;
			rec.merge_done = 1'b1;
		end else begin
			src = heap_src[0];
			rec.record_valid = 1'b1;
			rec.out_source = src;
			rec.out_key = head_key[src];
			rec.out_term = head_term[src];
			rec.same_term = prev_term_valid && head_term[src] == prev_term;
			rec.refill_source = src;
			prev_term = head_term[src];
			prev_term_valid = 1'b1;
		end
		expected_merge_out.push_back(rec);
	endfunction

	function automatic void merge_step(in_item_t it);
		int unsigned n;
		n = active_ways();
		if (it.command == CMD_START) begin
			heap_size = 0;
			loaded = 0;
			merging = 1'b1;
			prev_term_valid = 1'b0;
			prev_term = '0;
			return;
		end
		if (!merging || (it.command != CMD_RECORD && it.command != CMD_END))
			return;
		if (loaded < n) begin
			// Sources load strictly in order; an end of source leaves no head record.
			if (it.source != loaded)
				return;
			if (it.command == CMD_RECORD) begin
				head_key[it.source] = it.sort_key;
				head_term[it.source] = it.term_tag;
				heap_src[heap_size] = it.source;
				heap_size++;
			end
			loaded++;
			if (loaded < n)
				return;
			for (int i = heap_size / 2; i > 0; i--)
				sift_down_from(i - 1);
			emit_minimum();
			return;
		end
		if (heap_size == 0 || it.source != heap_src[0])
			return;
		if (it.command == CMD_RECORD) begin
			head_key[it.source] = it.sort_key;
			head_term[it.source] = it.term_tag;
		end else begin
			heap_size--;
			heap_src[0] = heap_src[heap_size];
		end
		if (heap_size > 1)
			sift_down_from(0);
		emit_minimum();
	endfunction

	function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_result(out_item_t got);
		out_item_t want;
		if (expected_merge_out.size() == 0) begin
			$display("%0t: result transaction with nothing expected: expected none, actual %h",
				$time, got);
			mismatches++;
			return;
		end
		want = expected_merge_out.pop_front();
		compare_field("record_valid", want.record_valid, got.record_valid);
		compare_field("out_source", want.out_source, got.out_source);
		compare_field("out_key", want.out_key, got.out_key);
		compare_field("out_term", want.out_term, got.out_term);
		compare_field("same_term", want.same_term, got.same_term);
		compare_field("refill_source", want.refill_source, got.refill_source);
		compare_field("merge_done", want.merge_done, got.merge_done);
	endfunction

	// Prediction runs before the comparison so that an item and a result in the same cycle
	// are handled correctly whatever the latency.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_sources = NUM_SOURCES_RESET;
			heap_size = 0;
			loaded = 0;
			merging = 1'b0;
			prev_term = '0;
			prev_term_valid = 1'b0;
			expected_merge_out.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == {REG_NUM_SOURCES, 2'b00})
				num_sources = pwdata[NUM_W-1:0];
			if (item_valid && item_ready)
				merge_step(item);
			if (result_valid && result_ready)
				check_result(result);
		end
		pending_results <= expected_merge_out.size();
		fail_count <= mismatches;
	end

endmodule

>>> verif/tb_kway_heap_merge.sv
// Top of the k-way heap merge testbench: clock, reset, register writes and item stimulus.
// Depends on kwm_pkg, kwm_stream_if, the kway_heap_merge block and kwm_merge_checker.
module tb_kway_heap_merge;
	timeunit 1ns;
	timeprecision 1ps;
	import kwm_pkg::*;

	// Command code the block does not use; it must be ignored.
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
	localparam int unsigned ITEMS_PER_PHASE = 475;
	localparam int unsigned SETTLE_CYCLES = 40;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned pending_results;
	int unsigned fail_count;

	int unsigned send_idle_pct = 38;
	int unsigned recv_idle_pct = 86;
	int unsigned items_sent = 0;
	int unsigned results_owed = 0;
	int unsigned results_seen;
	int unsigned n_ways = SRC_REACH;
	logic [SRC_W-1:0] last_refill;
	logic        last_done;

	kwm_stream_if #(.payload_t(in_item_t))  item_ch ();
	kwm_stream_if #(.payload_t(out_item_t)) result_ch ();

	kway_heap_merge dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	kwm_merge_checker merge_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_ch.valid),
		.item_ready      (item_ch.ready),
		.item            (item_ch.payload),
		.result_valid    (result_ch.valid),
		.result_ready    (result_ch.ready),
		.result          (result_ch.payload),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pending_results (pending_results),
		.fail_count      (fail_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_ch.ready <= 1'b0;
		else
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// The stimulus follows the merge by the refill source of the latest result transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
			last_refill <= '0;
			last_done <= 1'b0;
		end else if (result_ch.valid && result_ch.ready) begin
			results_seen <= results_seen + 1;
			last_refill <= result_ch.payload.refill_source;
			last_done <= result_ch.payload.merge_done;
		end
	end

	function automatic in_item_t make_item(logic [CMD_W-1:0] cmd, logic [SRC_W-1:0] src,
		logic [KEY_W-1:0] key, logic [TERM_W-1:0] term);
		in_item_t it;
		it.command = cmd;
		it.source = src;
		it.sort_key = key;
		it.term_tag = term;
		return it;
	endfunction

	// Mostly a small step up from the previous key, so ties and sorted runs are common.
	function automatic logic [KEY_W-1:0] next_key(logic [KEY_W-1:0] floor_key);
		logic [KEY_W-1:0] step;
		case ($urandom_range(9))
			0: return {$urandom, $urandom};
			1: return {32'hFFFF_FFFF, $urandom};
			default: begin
				step = KEY_W'($urandom_range(3));
				return (floor_key > ~step) ? '1 : floor_key + step;
			end
		endcase
	endfunction

	function automatic logic [TERM_W-1:0] pick_term();
		return ($urandom_range(4) == 0) ? $urandom : $urandom_range(3);
	endfunction

	task automatic send_item(input in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// An item the block must ignore: an unused command or a source other than the one awaited.
	task automatic send_noise(input logic [SRC_W-1:0] avoid);
		logic [CMD_W-1:0] cmd;
		case ($urandom_range(2))
			0: cmd = CMD_RESERVED;
			1: cmd = CMD_RECORD;
			default: cmd = CMD_END;
		endcase
		send_item(make_item(cmd, avoid + SRC_W'($urandom_range(1, 15)), {$urandom, $urandom},
			$urandom));
	endtask

	task automatic wait_for_results();
		if (results_seen < results_owed) begin
			item_ch.valid <= 1'b0;
			while (results_seen < results_owed)
				@(posedge clk);
		end
	endtask

	task automatic refill_with(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
		input logic [TERM_W-1:0] term);
		wait_for_results();
		send_item(make_item(cmd, last_refill, key, term));
		results_owed++;
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// The register changes only once the block has drained and settled.
	task automatic set_sources(input logic [NUM_W-1:0] value);
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0 || results_seen < results_owed)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg({REG_NUM_SOURCES, 2'b00}, 32'(value));
		n_ways = (value == 0) ? 1 : (value > SRC_REACH) ? SRC_REACH : value;
	endtask

	task automatic directed_checks();
		set_sources(NUM_W'(3));
		// Records and ends before any start are ignored.
		send_item(make_item(CMD_RECORD, SRC_W'(0), '1, '1));
		send_item(make_item(CMD_END, SRC_W'(0), '0, '0));
		send_item(make_item(CMD_START, '1, '1, '1));
		send_item(make_item(CMD_RESERVED, SRC_W'(0), '1, '1));
		send_item(make_item(CMD_RECORD, SRC_W'(1), KEY_W'(5), TERM_W'(5)));
		send_item(make_item(CMD_RECORD, SRC_W'(0), '1, '1));
		send_item(make_item(CMD_RECORD, SRC_W'(1), '0, '0));
		send_item(make_item(CMD_RECORD, SRC_W'(2), '0, TERM_W'(7)));
		results_owed++;
		// Equal keys stay with the parent; equal consecutive terms set the combine flag.
		refill_with(CMD_RECORD, '0, '0);
		wait_for_results();
		send_noise(last_refill);
		refill_with(CMD_END, '0, '0);
		refill_with(CMD_RECORD, '1, '1);
		refill_with(CMD_END, '0, '0);
		refill_with(CMD_END, '0, '0);
		send_item(make_item(CMD_RECORD, SRC_W'(0), KEY_W'(1), TERM_W'(1)));
		// Every source ends at once: the heap is empty straight after loading.
		send_item(make_item(CMD_START, SRC_W'(0), '0, '0));
		send_item(make_item(CMD_END, SRC_W'(0), '0, '0));
		send_item(make_item(CMD_END, SRC_W'(1), '0, '0));
		send_item(make_item(CMD_END, SRC_W'(2), '0, '0));
		results_owed++;
	endtask

	task automatic run_merge();
		int unsigned left_in [SRC_REACH];
		logic [KEY_W-1:0] floor_key [SRC_REACH];
		logic [SRC_W-1:0] src;
		int unsigned max_run;
		bit abandoned;
		abandoned = 1'b0;
		max_run = $urandom_range(3) == 0 ? 8 : 3;
		send_item(make_item(CMD_START, SRC_W'($urandom), {$urandom, $urandom}, $urandom));
		for (int i = 0; i < n_ways; i++) begin
			if ($urandom_range(9) == 0)
				send_noise(SRC_W'(i));
			left_in[i] = $urandom_range(max_run);
			floor_key[i] = next_key(KEY_W'($urandom_range(15)));
			if ($urandom_range(7) == 0)
				send_item(make_item(CMD_END, SRC_W'(i), {$urandom, $urandom}, $urandom));
			else
				send_item(make_item(CMD_RECORD, SRC_W'(i), floor_key[i], pick_term()));
		end
		results_owed++;
		forever begin
			wait_for_results();
			if (last_done)
				break;
			src = last_refill;
			if ($urandom_range(9) == 0)
				send_noise(src);
			if (left_in[src] == 0) begin
				send_item(make_item(CMD_END, src, {$urandom, $urandom}, $urandom));
			end else begin
				left_in[src]--;
				floor_key[src] = next_key(floor_key[src]);
				send_item(make_item(CMD_RECORD, src, floor_key[src], pick_term()));
			end
			results_owed++;
			// A start may cut a merge short while its last result is still outstanding.
			if ($urandom_range(99) == 0) begin
				abandoned = 1'b1;
				break;
			end
			if ($urandom_range(7) == 0)
				send_item(make_item(CMD_RESERVED, SRC_W'($urandom), {$urandom, $urandom},
					$urandom));
		end
		if (!abandoned && $urandom_range(3) == 0)
			send_noise(last_refill);
	endtask

	initial begin
		int unsigned target;
		int unsigned round;
		logic [NUM_W-1:0] value;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.payload <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_checks();
		round = 0;
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 86 : 0;
			recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 38 : 0;
			target = items_sent + ITEMS_PER_PHASE;
			while (items_sent < target) begin
				case (round % 7)
					0: value = NUM_W'(1);
					1: value = NUM_W'(16);
					2: value = NUM_W'(0);
					3: value = NUM_W'(31);
					4: value = NUM_W'(2);
					5: value = NUM_W'(9);
					default: value = NUM_W'($urandom_range(31));
				endcase
				set_sources(value);
				repeat (2) run_merge();
				round++;
			end
		end
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("kway_heap_merge verification clean");
		else
			$display("kway_heap_merge verification failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("kway_heap_merge verification failed");
		$finish;
	end

endmodule
